// File: rtl/dltq_pkg.sv
// dltq_pkg: shared types and constants for the delta-list alarm queue.
// No dependencies; used by delta_list_timer_queue.
`default_nettype none
package dltq_pkg;

   // request kind carried on req_tuser
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // outcome codes in rsp_tdata
   localparam logic [1:0] OUTCOME_ACCEPTED = 2'd0;
   localparam logic [1:0] OUTCOME_FULL     = 2'd1;
   localparam logic [1:0] OUTCOME_EXPIRED  = 2'd2;

   localparam int DELTA_W = 16;
   localparam int OWNER_W = 4;
   // most entries popped by a single tick
   localparam int MAX_POPS = 16;
   localparam int POP_W    = $clog2(MAX_POPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_WALK,
      ST_WR1,
      ST_WR2,
      ST_RESP,
      ST_TCHK,
      ST_TFLUSH
   } state_type;

endpackage
`default_nettype wire

// File: rtl/dltq_ram.sv
// dltq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; used by delta_list_timer_queue for all entry storage.
`default_nettype none
module dltq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/delta_list_timer_queue.sv
// delta_list_timer_queue: alarm queue kept as a delta list in on-chip RAM.
// Depends on dltq_pkg and dltq_ram.
//
// Usage:
//   req_* takes one word per request. req_tuser is the kind: insert or a
//   one-second tick. An insert answers one rsp word (accepted, or full when
//   all QUEUE_DEPTH entries are in use) with rsp_tlast high. A tick answers
//   one rsp word per expired owner, rsp_tlast high on the final one, or no
//   word at all when nothing is due. At most 16 entries pop per tick.
//   Requests are handled one at a time; req_tready is high only while idle.
//   Steps: an insert passes ALLOC, then WALK, which steps past one queued
//   entry per cycle (walk reads delta and link of each entry through the RAM
//   read port), then WR1, WR2 and RESP; a refused insert goes straight to
//   RESP. A tick checks one entry per TCHK step and ends in TFLUSH when it
//   stops on a pop. Each RAM takes one read and one write per cycle.
//   Results sit in an output register; when rsp_tready is low a finished
//   insert waits with its answer and a tick holds its pop in place until the
//   word is taken. The walk itself never waits on rsp_tready.
//   Reset empties the queue and the free list restarts at entry 0. The link
//   RAM needs no clearing pass: a fill count marks entries never allocated,
//   and those read as linking to the next entry.
`default_nettype none
module delta_list_timer_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [3:0] owner_id, [19:4] delay, [23:20] zero
   input  wire logic [0:0]  req_tuser,   // [0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [1:0] outcome, [5:2] result_owner, [7:6] zero
   output logic             rsp_tlast    // last_flag
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = dltq_pkg::DELTA_W;
   localparam int OW = dltq_pkg::OWNER_W;
   localparam int PW = dltq_pkg::POP_W;

   dltq_pkg::state_type state_ff, state_in;

   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] free_ff, free_in;
   logic [CW-1:0] used_ff, used_in;
   logic [IW-1:0] node_ff, node_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [CW-1:0] walked_ff, walked_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [OW-1:0] owner_ff, owner_in;
   logic [IW-1:0] free_next_ff, free_next_in;
   logic          first_ff, first_in;
   logic [PW-1:0] pop_cnt_ff, pop_cnt_in;
   logic [OW-1:0] pend_owner_ff, pend_owner_in;
   logic [1:0]    res_outcome_ff, res_outcome_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_outcome_ff, rsp_outcome_in;
   logic [OW-1:0] rsp_owner_ff, rsp_owner_in;
   logic          rsp_last_ff, rsp_last_in;

   // RAM ports
   logic          delta_we, owner_we, link_we;
   logic [IW-1:0] delta_wa, owner_wa, link_wa;
   logic [DW-1:0] delta_wd, delta_q;
   logic [OW-1:0] owner_wd, owner_q;
   logic [IW-1:0] link_wd, link_q;

   logic          accept, out_free, in_kind;
   logic [OW-1:0] in_owner;
   logic [DW-1:0] in_delay;
   logic [IW-1:0] link_rd, rd_next;
   logic [DW-1:0] tick_d;
   logic          tick_pop, tick_go, tick_more, walk_step, queue_full;

   dltq_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_delta_ram (
      .clock   (clock),
      .wr_en   (delta_we),
      .wr_addr (delta_wa),
      .wr_data (delta_wd),
      .rd_addr (rd_addr_in),
      .rd_data (delta_q)
   );

   dltq_ram #(.WIDTH(OW), .DEPTH(QUEUE_DEPTH)) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_we),
      .wr_addr (owner_wa),
      .wr_data (owner_wd),
      .rd_addr (rd_addr_in),
      .rd_data (owner_q)
   );

   dltq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (rd_addr_in),
      .rd_data (link_q)
   );

   assign in_kind  = req_tuser[0];
   assign in_owner = req_tdata[OW-1:0];
   assign in_delay = req_tdata[OW+DW-1:OW];

   assign req_tready = (state_ff == dltq_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign queue_full = (used_ff == CW'(QUEUE_DEPTH));

   // entries never allocated are not read from the link RAM: they link to the next index
   assign rd_next = (rd_addr_ff == IW'(QUEUE_DEPTH - 1)) ? '0 : rd_addr_ff + IW'(1);
   assign link_rd = ({{(CW-IW){1'b0}}, rd_addr_ff} >= fill_ff) ? rd_next : link_q;

   assign walk_step = (walked_ff < used_ff) && (rem_ff >= delta_q);

   // only the head gets decremented; followers pop only when already zero
   assign tick_d    = (first_ff && delta_q != '0) ? delta_q - DW'(1) : delta_q;
   assign tick_pop  = (tick_d == '0);
   assign tick_go   = first_ff || out_free;
   assign tick_more = (used_ff > CW'(1)) && (pop_cnt_ff < PW'(dltq_pkg::MAX_POPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dltq_pkg::ST_IDLE: begin
            if (accept) begin
               if (in_kind == dltq_pkg::KIND_INSERT) begin
                  state_in = queue_full ? dltq_pkg::ST_RESP : dltq_pkg::ST_ALLOC;
               end else begin
                  state_in = (used_ff == '0) ? dltq_pkg::ST_IDLE : dltq_pkg::ST_TCHK;
               end
            end
         end
         dltq_pkg::ST_ALLOC: state_in = dltq_pkg::ST_WALK;
         dltq_pkg::ST_WALK: begin
            if (!walk_step) begin
               state_in = dltq_pkg::ST_WR1;
            end
         end
         dltq_pkg::ST_WR1:   state_in = dltq_pkg::ST_WR2;
         dltq_pkg::ST_WR2:   state_in = dltq_pkg::ST_RESP;
         dltq_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = dltq_pkg::ST_IDLE;
            end
         end
         dltq_pkg::ST_TCHK: begin
            if (tick_go) begin
               if (!tick_pop) begin
                  state_in = dltq_pkg::ST_IDLE;
               end else if (tick_more) begin
                  state_in = dltq_pkg::ST_TCHK;
               end else begin
                  state_in = dltq_pkg::ST_TFLUSH;
               end
            end
         end
         dltq_pkg::ST_TFLUSH: begin
            if (out_free) begin
               state_in = dltq_pkg::ST_IDLE;
            end
         end
         default: state_in = dltq_pkg::ST_IDLE;
      endcase
   end

   // datapath, RAM control and result register
   always_comb begin
      rd_addr_in     = rd_addr_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      free_in        = free_ff;
      used_in        = used_ff;
      node_in        = node_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      walked_in      = walked_ff;
      rem_in         = rem_ff;
      owner_in       = owner_ff;
      free_next_in   = free_next_ff;
      first_in       = first_ff;
      pop_cnt_in     = pop_cnt_ff;
      pend_owner_in  = pend_owner_ff;
      res_outcome_in = res_outcome_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_owner_in   = rsp_owner_ff;
      rsp_last_in    = rsp_last_ff;
      delta_we       = 1'b0;
      delta_wa       = cur_ff;
      delta_wd       = delta_q;
      owner_we       = 1'b0;
      owner_wa       = node_ff;
      owner_wd       = owner_ff;
      link_we        = 1'b0;
      link_wa        = node_ff;
      link_wd        = cur_ff;

      case (state_ff)
         dltq_pkg::ST_IDLE: begin
            if (accept) begin
               owner_in = in_owner;
               rem_in   = in_delay;
               if (in_kind == dltq_pkg::KIND_INSERT) begin
                  res_outcome_in = queue_full ? dltq_pkg::OUTCOME_FULL
                                              : dltq_pkg::OUTCOME_ACCEPTED;
                  node_in    = free_ff;
                  rd_addr_in = free_ff;
               end else begin
                  rd_addr_in = head_ff;
                  first_in   = 1'b1;
                  pop_cnt_in = '0;
               end
            end
         end
         dltq_pkg::ST_ALLOC: begin
            free_next_in = link_rd;
            cur_in       = head_ff;
            prev_in      = head_ff;
            walked_in    = '0;
            rd_addr_in   = head_ff;
         end
         dltq_pkg::ST_WALK: begin
            if (walk_step) begin
               rem_in     = rem_ff - delta_q;
               prev_in    = cur_ff;
               cur_in     = link_rd;
               walked_in  = walked_ff + CW'(1);
               rd_addr_in = link_rd;
            end
         end
         dltq_pkg::ST_WR1: begin
            // follower keeps its expiry: its delta shrinks by the new delta
            delta_we = (walked_ff < used_ff);
            delta_wa = cur_ff;
            delta_wd = delta_q - rem_ff;
            owner_we = 1'b1;
            owner_wa = node_ff;
            owner_wd = owner_ff;
            link_we  = 1'b1;
            link_wa  = node_ff;
            link_wd  = cur_ff;
         end
         dltq_pkg::ST_WR2: begin
            delta_we = 1'b1;
            delta_wa = node_ff;
            delta_wd = rem_ff;
            if (walked_ff != '0) begin
               link_we = 1'b1;
               link_wa = prev_ff;
               link_wd = node_ff;
            end else begin
               head_in = node_ff;
            end
            used_in = used_ff + CW'(1);
            free_in = free_next_ff;
            if (fill_ff < CW'(QUEUE_DEPTH) && {{(CW-IW){1'b0}}, node_ff} == fill_ff) begin
               fill_in = fill_ff + CW'(1);
            end
         end
         dltq_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_owner_in   = owner_ff;
               rsp_last_in    = 1'b1;
            end
         end
         dltq_pkg::ST_TCHK: begin
            if (tick_go) begin
               if (first_ff) begin
                  delta_we = 1'b1;
                  delta_wa = rd_addr_ff;
                  delta_wd = tick_d;
               end else begin
                  // the held owner goes out once we know whether more follow
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = dltq_pkg::OUTCOME_EXPIRED;
                  rsp_owner_in   = pend_owner_ff;
                  rsp_last_in    = !tick_pop;
               end
               first_in = 1'b0;
               if (tick_pop) begin
                  pend_owner_in = owner_q;
                  pop_cnt_in    = pop_cnt_ff + PW'(1);
                  head_in       = link_rd;
                  link_we       = 1'b1;
                  link_wa       = rd_addr_ff;
                  link_wd       = free_ff;
                  free_in       = rd_addr_ff;
                  used_in       = used_ff - CW'(1);
                  rd_addr_in    = link_rd;
               end
            end
         end
         dltq_pkg::ST_TFLUSH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = dltq_pkg::OUTCOME_EXPIRED;
               rsp_owner_in   = pend_owner_ff;
               rsp_last_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dltq_pkg::ST_IDLE;
         fill_ff      <= '0;
         head_ff      <= '0;
         free_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         pop_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         pop_cnt_ff   <= pop_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      node_ff        <= node_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      walked_ff      <= walked_in;
      rem_ff         <= rem_in;
      owner_ff       <= owner_in;
      free_next_ff   <= free_next_in;
      pend_owner_ff  <= pend_owner_in;
      res_outcome_ff <= res_outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_owner_ff   <= rsp_owner_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_owner_ff, rsp_outcome_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
